[rtl/mqsp_pkg.sv]
package mqsp_pkg;

   localparam int DIRECTIONS  = 2;
   localparam int QUEUE_DEPTH = 64;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_PEEK   = 2'd1,
      MODE_POP    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      mode_type    mode;
      logic        direction;
      logic [7:0]  priority_req;
      logic [15:0] ready_time;
      logic [7:0]  entry_id;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        head_valid;
      logic [7:0]  head_priority;
      logic [15:0] head_load_time;
      logic [7:0]  head_id;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] ready_time;
      logic [7:0]  id;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type entry;
   } cell_cmd_type;

   // Held entry is served no later than the incoming one (equal keys stay ahead).
   function automatic logic goes_before(entry_type held, entry_type incoming);
      logic pri_gt;
      logic pri_eq;
      pri_gt = held.prio > incoming.prio;
      pri_eq = held.prio == incoming.prio;
      return pri_gt ||
         (pri_eq && ({held.ready_time, held.id} <= {incoming.ready_time, incoming.id}));
   endfunction

endpackage

[rtl/mqsp_cell.sv]
module mqsp_cell import mqsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  entry_type    left_entry,
   input  logic         left_valid,
   input  logic         left_before,
   input  entry_type    right_entry,
   input  logic         right_valid,
   output entry_type    entry,
   output logic         valid,
   output logic         stays
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   assign entry = entry_ff;
   assign valid = valid_ff;
   assign stays = valid_ff && goes_before(entry_ff, cmd.entry);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (cmd.insert) begin
         if (!stays) begin
            if (left_before) begin
               // first slot past the ones that stay: drop the new word here
               entry_in = cmd.entry;
               valid_in = 1'b1;
            end else begin
               // advance the left neighbor one slot back
               entry_in = left_entry;
               valid_in = left_valid;
            end
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[rtl/multi_queue_sorted_priority_queue_top.sv]
// Channel  Direction  Handshake           Word
// req      in         req_valid/req_stall req_type: mode, direction, entry fields
// rsp      out        rsp_valid/rsp_stall rsp_type: status, head fields
//
// One item per cycle unless req is stalled: each queue is a chain of QUEUE_DEPTH
// sorted cells that all compare against the incoming entry and shift in the same
// cycle. The output register takes the result in the cycle after the item is
// accepted. Reset clears the cell valid bits; the block takes items right away.
// A stalled result holds in the output register and stalls req until taken.
module multi_queue_sorted_priority_queue_top import mqsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   entry_type    cell_entry  [DIRECTIONS][QUEUE_DEPTH];
   logic         cell_valid  [DIRECTIONS][QUEUE_DEPTH];
   logic         cell_before [DIRECTIONS][QUEUE_DEPTH];
   cell_cmd_type cell_cmd    [DIRECTIONS];

   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_word_ff, rsp_word_in;
   logic      req_take;
   logic      dir_ok;
   logic      sel_full;
   logic      sel_empty;
   entry_type sel_head;
   entry_type new_entry;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign new_entry.prio       = req_word.priority_req;
   assign new_entry.ready_time = req_word.ready_time;
   assign new_entry.id         = req_word.entry_id;
   assign dir_ok = int'(req_word.direction) < DIRECTIONS;

   always_comb begin
      sel_full  = 1'b1;
      sel_empty = 1'b1;
      sel_head  = '0;
      for (int d = 0; d < DIRECTIONS; d++) begin
         if (int'(req_word.direction) == d) begin
            sel_full  = cell_valid[d][QUEUE_DEPTH-1];
            sel_empty = !cell_valid[d][0];
            sel_head  = cell_entry[d][0];
         end
      end
   end

   genvar gd, gi;
   generate
      for (gd = 0; gd < DIRECTIONS; gd++) begin : g_dir
         always_comb begin
            cell_cmd[gd].entry  = new_entry;
            cell_cmd[gd].insert = req_take && (req_word.mode == MODE_INSERT) &&
               (int'(req_word.direction) == gd) && !cell_valid[gd][QUEUE_DEPTH-1];
            cell_cmd[gd].pop    = req_take && (req_word.mode == MODE_POP) &&
               (int'(req_word.direction) == gd) && cell_valid[gd][0];
         end

         for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            entry_type l_entry, r_entry;
            logic      l_valid, l_before, r_valid;

            if (gi == 0) begin : g_first
               assign l_entry  = new_entry;
               assign l_valid  = 1'b1;
               assign l_before = 1'b1;
            end else begin : g_mid_l
               assign l_entry  = cell_entry[gd][gi-1];
               assign l_valid  = cell_valid[gd][gi-1];
               assign l_before = cell_before[gd][gi-1];
            end

            if (gi == QUEUE_DEPTH-1) begin : g_last
               assign r_entry = new_entry;
               assign r_valid = 1'b0;
            end else begin : g_mid_r
               assign r_entry = cell_entry[gd][gi+1];
               assign r_valid = cell_valid[gd][gi+1];
            end

            mqsp_cell u_cell (
               .clock       (clock),
               .reset       (reset),
               .cmd         (cell_cmd[gd]),
               .left_entry  (l_entry),
               .left_valid  (l_valid),
               .left_before (l_before),
               .right_entry (r_entry),
               .right_valid (r_valid),
               .entry       (cell_entry[gd][gi]),
               .valid       (cell_valid[gd][gi]),
               .stays       (cell_before[gd][gi])
            );
         end
      end
   endgenerate

   always_comb begin
      rsp_word_in = '0;
      unique case (req_word.mode)
         MODE_INSERT: begin
            if (!dir_ok || sel_full) begin
               rsp_word_in.status = STATUS_FULL;
            end
         end
         MODE_PEEK: begin
            if (!dir_ok || sel_empty) begin
               rsp_word_in.status = STATUS_EMPTY;
            end else begin
               rsp_word_in.head_valid     = 1'b1;
               rsp_word_in.head_priority  = sel_head.prio;
               rsp_word_in.head_load_time = sel_head.ready_time;
               rsp_word_in.head_id        = sel_head.id;
            end
         end
         MODE_POP: begin
            if (!dir_ok || sel_empty) begin
               rsp_word_in.status = STATUS_EMPTY;
            end
         end
         default: begin
            rsp_word_in = '0;
         end
      endcase
   end

   always_comb begin
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the word while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

[rtl/mqsp_checker.sv]
module mqsp_checker import mqsp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed or dropped");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word gave no result next cycle");

   a_stall_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled with output free");

   a_head_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.head_valid |-> rsp_word.status == STATUS_OK)
      else $error("head returned with error status");

   a_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.head_valid |->
         rsp_word.head_priority == '0 && rsp_word.head_load_time == '0 &&
         rsp_word.head_id == '0)
      else $error("head fields set without a head");

endmodule

bind multi_queue_sorted_priority_queue_top mqsp_checker u_mqsp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

[verif/multi_queue_sorted_priority_queue_top_tb.sv]
`timescale 1ns / 100ps

module multi_queue_sorted_priority_queue_top_tb import mqsp_pkg::*;;

   localparam int STUCK_LIMIT  = 1000;
   localparam int RANDOM_ITEMS = 800;
   localparam int TAIL_START   = 700;

   localparam mode_type MODE_UNUSED = mode_type'(2'd3);

   localparam rsp_type RSP_OK    = '{STATUS_OK, 1'b0, 8'h00, 16'h0000, 8'h00};
   localparam rsp_type RSP_EMPTY = '{STATUS_EMPTY, 1'b0, 8'h00, 16'h0000, 8'h00};

   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_type;

   typedef struct {
      req_type word;
      logic    typed;
      rsp_type want;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_word;

   // travel with req_word so the checker knows which expectation the row carries
   logic    row_typed;
   rsp_type row_want;

   logic    gaps_on = 1'b1;
   logic    quiet_tail = 1'b0;
   int      stall_left = 0;
   int      idle_cycles = 0;
   int      fail_count = 0;

   entry_type        queued_entries[DIRECTIONS][$];
   rsp_type          expected_results[$];
   rsp_type          want_rsp;
   directed_row_type directed_rows[$];

   multi_queue_sorted_priority_queue_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // smaller key is served first
   function automatic logic [31:0] serve_key(entry_type e);
      return {8'hFF - e.prio, e.ready_time, e.id};
   endfunction

   function automatic rsp_type apply_queue_op(req_type w);
      rsp_type   r;
      entry_type e;
      int        d;
      int        pos;
      r = '0;
      d = w.direction;
      e = '{w.priority_req, w.ready_time, w.entry_id};
      case (w.mode)
         MODE_INSERT: begin
            if (queued_entries[d].size() >= QUEUE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               // equal keys stay ahead of the new entry
               pos = 0;
               while (pos < queued_entries[d].size() &&
                      serve_key(queued_entries[d][pos]) <= serve_key(e))
                  pos++;
               queued_entries[d].insert(pos, e);
            end
         end
         MODE_PEEK: begin
            if (queued_entries[d].size() == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.head_valid     = 1'b1;
               r.head_priority  = queued_entries[d][0].prio;
               r.head_load_time = queued_entries[d][0].ready_time;
               r.head_id        = queued_entries[d][0].id;
            end
         end
         MODE_POP: begin
            if (queued_entries[d].size() == 0) r.status = STATUS_EMPTY;
            else void'(queued_entries[d].pop_front());
         end
         default: ;
      endcase
      return r;
   endfunction

   // lean toward extremes and tiny values so ties in the sort key are common
   function automatic logic [15:0] random_field();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         1: return 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_word(phase_kind_type kind, logic fav_dir);
      req_type    w;
      int         roll;
      int         ins_pct;
      int         pop_pct;
      int         peek_pct;
      logic [15:0] f;
      case (kind)
         PH_FILL: begin
            ins_pct = 75; pop_pct = 12; peek_pct = 10;
         end
         PH_DRAIN: begin
            ins_pct = 8; pop_pct = 75; peek_pct = 14;
         end
         default: begin
            ins_pct = 40; pop_pct = 30; peek_pct = 27;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) w.mode = MODE_INSERT;
      else if (roll < ins_pct + pop_pct) w.mode = MODE_POP;
      else if (roll < ins_pct + pop_pct + peek_pct) w.mode = MODE_PEEK;
      else w.mode = MODE_UNUSED;
      w.direction = ($urandom_range(0, 99) < 85) ? fav_dir : ~fav_dir;
      f = random_field();
      w.priority_req = f[7:0];
      w.ready_time = random_field();
      f = random_field();
      w.entry_id = f[7:0];
      return w;
   endfunction

   task automatic add_row(req_type w, logic typed, rsp_type want);
      directed_row_type row;
      row.word  = w;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   task automatic send_word(req_type w, logic typed, rsp_type want);
      if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      row_typed <= typed;
      row_want  <= want;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (!gaps_on || quiet_tail) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // predict on each accepted request, check each accepted result, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want_rsp = apply_queue_op(req_word);
            if (row_typed) expected_results.push_back(row_want);
            else expected_results.push_back(want_rsp);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("word with nothing pending", int'(rsp_word), 0);
            end else begin
               want_rsp = expected_results.pop_front();
               if (rsp_word.status !== want_rsp.status)
                  report_mismatch("status", int'(rsp_word.status), int'(want_rsp.status));
               if (rsp_word.head_valid !== want_rsp.head_valid)
                  report_mismatch("head_valid", int'(rsp_word.head_valid),
                                  int'(want_rsp.head_valid));
               if (rsp_word.head_priority !== want_rsp.head_priority)
                  report_mismatch("head_priority", int'(rsp_word.head_priority),
                                  int'(want_rsp.head_priority));
               if (rsp_word.head_load_time !== want_rsp.head_load_time)
                  report_mismatch("head_load_time", int'(rsp_word.head_load_time),
                                  int'(want_rsp.head_load_time));
               if (rsp_word.head_id !== want_rsp.head_id)
                  report_mismatch("head_id", int'(rsp_word.head_id), int'(want_rsp.head_id));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STUCK_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int             i;
      phase_kind_type kind;
      logic           fav_dir;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      row_typed <= 1'b0;
      row_want  <= RSP_OK;

      add_row('{MODE_PEEK, 1'b0, 8'h00, 16'h0000, 8'h00}, 1'b1, RSP_EMPTY);
      add_row('{MODE_POP, 1'b0, 8'h00, 16'h0000, 8'h00}, 1'b1, RSP_EMPTY);
      add_row('{MODE_PEEK, 1'b1, 8'h00, 16'h0000, 8'h00}, 1'b1, RSP_EMPTY);
      add_row('{MODE_POP, 1'b1, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1, RSP_EMPTY);
      add_row('{MODE_UNUSED, 1'b1, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1, RSP_OK);
      add_row('{MODE_INSERT, 1'b0, 8'h00, 16'h0000, 8'h00}, 1'b1, RSP_OK);
      add_row('{MODE_PEEK, 1'b0, 8'h00, 16'h0000, 8'h00}, 1'b1,
              '{STATUS_OK, 1'b1, 8'h00, 16'h0000, 8'h00});
      add_row('{MODE_INSERT, 1'b0, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1, RSP_OK);
      add_row('{MODE_PEEK, 1'b0, 8'h00, 16'h0000, 8'h00}, 1'b1,
              '{STATUS_OK, 1'b1, 8'hFF, 16'hFFFF, 8'hFF});
      add_row('{MODE_INSERT, 1'b0, 8'hFF, 16'h0000, 8'h00}, 1'b1, RSP_OK);
      add_row('{MODE_PEEK, 1'b0, 8'h00, 16'h0000, 8'h00}, 1'b1,
              '{STATUS_OK, 1'b1, 8'hFF, 16'h0000, 8'h00});
      // equal entry goes behind the one already there
      add_row('{MODE_INSERT, 1'b0, 8'hFF, 16'h0000, 8'h00}, 1'b1, RSP_OK);
      add_row('{MODE_INSERT, 1'b1, 8'h80, 16'h0005, 8'h03}, 1'b1, RSP_OK);
      add_row('{MODE_INSERT, 1'b1, 8'h80, 16'h0005, 8'h02}, 1'b1, RSP_OK);
      add_row('{MODE_INSERT, 1'b1, 8'h80, 16'h0004, 8'h09}, 1'b1, RSP_OK);
      add_row('{MODE_PEEK, 1'b1, 8'h00, 16'h0000, 8'h00}, 1'b0, RSP_OK);
      add_row('{MODE_POP, 1'b1, 8'h00, 16'h0000, 8'h00}, 1'b0, RSP_OK);
      add_row('{MODE_PEEK, 1'b1, 8'h00, 16'h0000, 8'h00}, 1'b0, RSP_OK);
      add_row('{MODE_POP, 1'b1, 8'h00, 16'h0000, 8'h00}, 1'b0, RSP_OK);
      add_row('{MODE_PEEK, 1'b1, 8'h00, 16'h0000, 8'h00}, 1'b0, RSP_OK);
      add_row('{MODE_POP, 1'b1, 8'h00, 16'h0000, 8'h00}, 1'b1, RSP_OK);
      add_row('{MODE_POP, 1'b1, 8'h00, 16'h0000, 8'h00}, 1'b1, RSP_EMPTY);
      add_row('{MODE_POP, 1'b0, 8'h00, 16'h0000, 8'h00}, 1'b0, RSP_OK);
      add_row('{MODE_PEEK, 1'b0, 8'h00, 16'h0000, 8'h00}, 1'b0, RSP_OK);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].want);

      // fill each queue past full, drain it, then mix both
      fav_dir = 1'b0;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) begin
            gaps_on    <= ($urandom_range(0, 3) != 0);
            quiet_tail <= (i >= TAIL_START);
         end
         case (i / 100)
            0, 1: begin kind = PH_FILL;  fav_dir = 1'b0; end
            2:    begin kind = PH_DRAIN; fav_dir = 1'b0; end
            3, 4: begin kind = PH_FILL;  fav_dir = 1'b1; end
            5:    begin kind = PH_DRAIN; fav_dir = 1'b1; end
            default: begin
               kind = PH_MIXED;
               if (i % 100 == 0) fav_dir = 1'($urandom_range(0, 1));
            end
         endcase
         send_word(random_word(kind, fav_dir), 1'b0, RSP_OK);
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
rtl/mqsp_pkg.sv
rtl/mqsp_cell.sv
rtl/multi_queue_sorted_priority_queue_top.sv
rtl/mqsp_checker.sv
verif/multi_queue_sorted_priority_queue_top_tb.sv
